[design/assert_macros.svh]
// Assertion shorthands used by pinhole_projection_with_distortion.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

[design/pinproj_pkg.sv]
// Shared widths, reset values and register codes for the pinhole projection block.
// No dependencies; used by pinproj_div and pinhole_projection_with_distortion.
package pinproj_pkg;

  localparam int CAM_W     = 50;  // camera coordinate, signed, 30 fraction bits
  localparam int MAG_W     = 48;  // magnitude of a camera coordinate
  localparam int NORM_INT  = 22;  // integer bits of u and v
  localparam int NORM_FRAC = 20;  // fraction bits of u and v
  localparam int QBITS     = NORM_INT + NORM_FRAC;
  localparam int NORM_W    = QBITS + 1;
  localparam int DIV_LAT   = QBITS + 2;
  localparam int POST_STAGES = 10;

  localparam int DIST_W = 24;
  localparam logic signed [NORM_W-1:0] DIST_MAX = NORM_W'((64'sd1 <<< 23) - 64'sd1);

  localparam logic [47:0] ROT0_RST = 48'h0000_0000_4000;
  localparam logic [47:0] ROT1_RST = 48'h0000_4000_0000;
  localparam logic [47:0] ROT2_RST = 48'h4000_0000_0000;
  localparam logic [63:0] INTR_RST = 64'h1680_2800_1F40_1F40;

  localparam logic [15:0] PIX_BEHIND = 16'hFFF0;

  typedef enum logic [2:0] {
    REG_ROT0  = 3'd0,
    REG_ROT1  = 3'd1,
    REG_ROT2  = 3'd2,
    REG_TX    = 3'd3,
    REG_TY    = 3'd4,
    REG_TZ    = 3'd5,
    REG_INTR  = 3'd6,
    REG_DIST  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic behind;
  } tag_t;

  // Clamp a normalized coordinate to the distortion range.
  function automatic logic signed [DIST_W-1:0] dist_clamp(input logic signed [NORM_W-1:0] x);
    logic signed [DIST_W-1:0] res;
    if (x > DIST_MAX) begin
      res = DIST_W'(DIST_MAX);
    end else if (x < -DIST_MAX) begin
      res = DIST_W'(-DIST_MAX);
    end else begin
      res = x[DIST_W-1:0];
    end
    return res;
  endfunction

endpackage

[design/pinproj_div.sv]
// Pipelined restoring divider: num / den with NORM_FRAC fraction bits, toward zero.
// One quotient bit per stage; depends on pinproj_pkg.
module pinproj_div import pinproj_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [CAM_W-1:0]  num,
  input  logic signed [CAM_W-1:0]  den,
  output logic signed [NORM_W-1:0] quo
);

  logic [MAG_W-1:0] den_r  [0:QBITS];
  logic [MAG_W-1:0] rem_r  [0:QBITS];
  logic [QBITS-1:0] bits_r [0:QBITS];
  logic [QBITS-1:0] qacc_r [0:QBITS];
  logic             neg_r  [0:QBITS];
  logic             ovf_r  [0:QBITS];
  logic signed [NORM_W-1:0] quo_r;

  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] dmag;
  logic [QBITS-1:0] qmag;

  always_comb begin
    mag  = num[CAM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    dmag = den[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= dmag;
      neg_r[0]  <= num[CAM_W-1];
      // quotient would need more than NORM_INT integer bits
      ovf_r[0]  <= {{NORM_INT{1'b0}}, mag} >= {dmag, {NORM_INT{1'b0}}};
      rem_r[0]  <= mag >> NORM_INT;
      bits_r[0] <= {mag[NORM_INT-1:0], {NORM_FRAC{1'b0}}};
      qacc_r[0] <= '0;
    end
  end

  for (genvar i = 1; i <= QBITS; i++) begin : g_step
    logic [MAG_W:0] trial;
    logic           ge;
    always_comb begin
      trial = {rem_r[i-1], bits_r[i-1][QBITS-1]};
      ge    = trial >= {1'b0, den_r[i-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i]  <= den_r[i-1];
        neg_r[i]  <= neg_r[i-1];
        ovf_r[i]  <= ovf_r[i-1];
        bits_r[i] <= bits_r[i-1] << 1;
        qacc_r[i] <= {qacc_r[i-1][QBITS-2:0], ge};
        rem_r[i]  <= ge ? MAG_W'(trial - {1'b0, den_r[i-1]}) : trial[MAG_W-1:0];
      end
    end
  end

  always_comb begin
    qmag = ovf_r[QBITS] ? {QBITS{1'b1}} : qacc_r[QBITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= neg_r[QBITS] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end
  end

  assign quo = quo_r;

endmodule

[design/pinhole_projection_with_distortion.sv]
// Pinhole camera projection with radial and tangential lens distortion.
// Stream in world points, stream out pixels. Channels:
//   in_*  : one world point per item (x, y, z signed Q16.16).
//   out_* : one pixel per item (x, y signed Q12.4) plus behind/saturated flags.
//   cfg_* : register writes (rotation rows, translation, intrinsics, distortion),
//           always ready, to be issued only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. Each item
// passes through the camera-frame stages, the 42-step pipelined divider (one
// quotient bit per stage) and the distortion and scaling stages after it.
// The whole pipeline advances together; when out_tready is low with a result
// waiting, every stage holds and in_tready drops, so nothing is lost or repeated.
// in_tready stays high while the output register is empty or being drained.
// Reset (synchronous, rst_n low) clears all valid bits and loads identity
// rotation, zero translation, default intrinsics and disabled distortion.
// Points with depth <= 0 give pixel (-1,-1) with behind_camera set.
`include "assert_macros.svh"
module pinhole_projection_with_distortion import pinproj_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // world_x, world_y, world_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_x, pixel_y
  output logic [1:0]  out_tuser,  // behind_camera, saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [47:0]        rot_r   [3];
  logic signed [31:0] trans_r [3];
  logic [63:0]        intr_r;
  logic [63:0]        dist_r;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0]   <= ROT0_RST;
      rot_r[1]   <= ROT1_RST;
      rot_r[2]   <= ROT2_RST;
      trans_r[0] <= '0;
      trans_r[1] <= '0;
      trans_r[2] <= '0;
      intr_r     <= INTR_RST;
      dist_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROT0: rot_r[0]   <= cfg_data[47:0];
        REG_ROT1: rot_r[1]   <= cfg_data[47:0];
        REG_ROT2: rot_r[2]   <= cfg_data[47:0];
        REG_TX:   trans_r[0] <= cfg_data[31:0];
        REG_TY:   trans_r[1] <= cfg_data[31:0];
        REG_TZ:   trans_r[2] <= cfg_data[31:0];
        REG_INTR: intr_r     <= cfg_data;
        REG_DIST: dist_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [15:0] k1, k2, p1, p2;
  logic signed [16:0] fx, fy, cx, cy;
  always_comb begin
    k1 = dist_r[15:0];
    k2 = dist_r[31:16];
    p1 = dist_r[47:32];
    p2 = dist_r[63:48];
    fx = {1'b0, intr_r[15:0]};
    fy = {1'b0, intr_r[31:16]};
    cx = {1'b0, intr_r[47:32]};
    cy = {1'b0, intr_r[63:48]};
  end

  // ---- camera frame: products, then sums
  logic signed [31:0] w [3];
  always_comb begin
    w[0] = in_tdata[31:0];
    w[1] = in_tdata[63:32];
    w[2] = in_tdata[95:64];
  end

  logic               v1_r, v2_r;
  logic signed [47:0] prod1_r  [3][3];
  logic signed [45:0] trans1_r [3];
  logic signed [CAM_W-1:0] cam2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int e = 0; e < 3; e++) begin
          prod1_r[r][e] <= $signed(rot_r[r][16*e +: 16]) * w[e];
        end
        trans1_r[r] <= 46'(trans_r[r]) <<< 14;
        cam2_r[r]   <= CAM_W'(prod1_r[r][0]) + CAM_W'(prod1_r[r][1])
                     + CAM_W'(prod1_r[r][2]) + CAM_W'(trans1_r[r]);
      end
    end
  end

  // ---- normalize by depth
  logic signed [NORM_W-1:0] u_div, v_div;

  pinproj_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (cam2_r[0]),
    .den (cam2_r[2]),
    .quo (u_div)
  );

  pinproj_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (cam2_r[1]),
    .den (cam2_r[2]),
    .quo (v_div)
  );

  tag_t sd_r  [0:DIV_LAT-1];
  tag_t tag_r [0:POST_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) sd_r[i] <= '0;
      for (int i = 0; i < POST_STAGES; i++) tag_r[i] <= '0;
    end else if (en) begin
      sd_r[0].valid  <= v2_r;
      sd_r[0].behind <= cam2_r[2][CAM_W-1] || (cam2_r[2] == '0);
      for (int i = 1; i < DIV_LAT; i++) sd_r[i] <= sd_r[i-1];
      tag_r[0] <= sd_r[DIV_LAT-1];
      for (int i = 1; i < POST_STAGES; i++) tag_r[i] <= tag_r[i-1];
    end
  end

  // ---- distortion
  logic signed [DIST_W-1:0] ud_r [0:6];
  logic signed [DIST_W-1:0] vd_r [0:6];
  logic signed [NORM_W-1:0] un_r [0:7];
  logic signed [NORM_W-1:0] vn_r [0:7];

  logic signed [26:0] uu_r, vv_r;
  logic signed [27:0] uv1_r, uv2_r;
  logic signed [28:0] r2_r;
  logic signed [29:0] rru_r, rrv_r;
  logic signed [57:0] r4p_r;
  logic signed [44:0] k1r2_r, k1r2b_r;
  logic signed [44:0] tu1_r, tv1_r;
  logic signed [45:0] tu2_r, tv2_r;
  logic signed [51:0] k2r4_r;
  logic signed [34:0] tgu_r [0:2];
  logic signed [34:0] tgv_r [0:2];
  logic signed [40:0] rad_r;
  logic signed [64:0] urad_r, vrad_r;
  logic signed [47:0] du_r, dv_r;
  logic signed [64:0] pxp_r, pyp_r;

  logic signed [47:0] sq_u, sq_v, sq_uv;
  logic signed [28:0] r2_sum;
  logic signed [35:0] r4;
  logic signed [47:0] nx, ny;

  always_comb begin
    sq_u   = ud_r[0] * ud_r[0];
    sq_v   = vd_r[0] * vd_r[0];
    sq_uv  = ud_r[0] * vd_r[0];
    r2_sum = 29'(uu_r) + 29'(vv_r);
    r4     = 36'(r4p_r >>> 20);
    nx     = (k1 != '0) ? du_r : 48'(un_r[7]);
    ny     = (k1 != '0) ? dv_r : 48'(vn_r[7]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // P0: clamp to distortion range
      ud_r[0] <= dist_clamp(u_div);
      vd_r[0] <= dist_clamp(v_div);
      un_r[0] <= u_div;
      vn_r[0] <= v_div;
      for (int i = 1; i < 7; i++) begin
        ud_r[i] <= ud_r[i-1];
        vd_r[i] <= vd_r[i-1];
      end
      for (int i = 1; i < 8; i++) begin
        un_r[i] <= un_r[i-1];
        vn_r[i] <= vn_r[i-1];
      end
      // P1: squares and cross term
      uu_r  <= 27'(sq_u >>> 20);
      vv_r  <= 27'(sq_v >>> 20);
      uv1_r <= 28'(sq_uv >>> 20);
      // P2: r^2 and tangential sums
      r2_r  <= r2_sum;
      rru_r <= 30'(r2_sum) + (30'(uu_r) <<< 1);
      rrv_r <= 30'(r2_sum) + (30'(vv_r) <<< 1);
      uv2_r <= uv1_r;
      // P3: first products
      r4p_r  <= r2_r * r2_r;
      k1r2_r <= k1 * r2_r;
      tu1_r  <= 45'(p1 * uv2_r) <<< 1;
      tu2_r  <= p2 * rru_r;
      tv1_r  <= 45'(p2 * uv2_r) <<< 1;
      tv2_r  <= p1 * rrv_r;
      // P4
      k2r4_r   <= k2 * r4;
      k1r2b_r  <= k1r2_r;
      tgu_r[0] <= 35'((48'(tu1_r) + 48'(tu2_r)) >>> 12);
      tgv_r[0] <= 35'((48'(tv1_r) + 48'(tv2_r)) >>> 12);
      // P5: radial factor
      rad_r    <= 41'((54'(k1r2b_r) + 54'(k2r4_r)) >>> 12);
      tgu_r[1] <= tgu_r[0];
      tgv_r[1] <= tgv_r[0];
      // P6
      urad_r   <= ud_r[5] * rad_r;
      vrad_r   <= vd_r[5] * rad_r;
      tgu_r[2] <= tgu_r[1];
      tgv_r[2] <= tgv_r[1];
      // P7: distorted coordinates
      du_r <= 48'(ud_r[6]) + 48'(urad_r >>> 20) + 48'(tgu_r[2]);
      dv_r <= 48'(vd_r[6]) + 48'(vrad_r >>> 20) + 48'(tgv_r[2]);
      // P8: focal scaling
      pxp_r <= fx * nx;
      pyp_r <= fy * ny;
    end
  end

  // ---- P9: round, offset, clamp
  logic signed [65:0] psx, psy;
  logic [15:0] px_nxt, py_nxt;
  logic        sat_nxt;
  logic [15:0] px_r, py_r;
  logic        sat_r;

  always_comb begin
    psx = ((66'(pxp_r) + 66'sd524288) >>> 20) + 66'(cx);
    psy = ((66'(pyp_r) + 66'sd524288) >>> 20) + 66'(cy);
    sat_nxt = 1'b0;
    if (psx > 66'sd32767) begin
      px_nxt  = 16'h7FFF;
      sat_nxt = 1'b1;
    end else if (psx < -66'sd32768) begin
      px_nxt  = 16'h8000;
      sat_nxt = 1'b1;
    end else begin
      px_nxt = psx[15:0];
    end
    if (psy > 66'sd32767) begin
      py_nxt  = 16'h7FFF;
      sat_nxt = 1'b1;
    end else if (psy < -66'sd32768) begin
      py_nxt  = 16'h8000;
      sat_nxt = 1'b1;
    end else begin
      py_nxt = psy[15:0];
    end
    if (tag_r[POST_STAGES-2].behind) begin
      px_nxt  = PIX_BEHIND;
      py_nxt  = PIX_BEHIND;
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_tvalid = tag_r[POST_STAGES-1].valid;
  assign out_tdata  = {py_r, px_r};
  assign out_tuser  = {sat_r, tag_r[POST_STAGES-1].behind};

  `ASSERT_IMPL(a_behind_px, out_tvalid && out_tuser[0], out_tdata == 32'hFFF0FFF0 && !out_tuser[1], "behind item with wrong pixel")
  `ASSERT_IMPL(a_sat_limit, out_tvalid && out_tuser[1], out_tdata[15:0] == 16'h7FFF || out_tdata[15:0] == 16'h8000 || out_tdata[31:16] == 16'h7FFF || out_tdata[31:16] == 16'h8000, "saturated item not at a limit")
  `ASSERT_ALWAYS(a_ready_empty, out_tvalid || in_tready, "input stalled with empty output")

endmodule
